/* rtl/bff_pkg.sv */
// ----------------------------------------------------------------------------
// bff_pkg
// shared sizes, command and status codes and control types for the bit fifo
// field extractor
// ----------------------------------------------------------------------------
package bff_pkg;

  // store and field sizes
  localparam int DEPTH_BITS = 256;
  localparam int PTR_W      = $clog2(DEPTH_BITS);
  localparam int FILL_W     = PTR_W + 1;
  localparam int MAX_POP    = 32;
  localparam int VAL_W      = 32;
  localparam int VAL_IDX_W  = $clog2(VAL_W);
  localparam int CNT_W      = 6;
  localparam int CMD_W      = 3;
  localparam int ST_W       = 2;
  localparam int BYTE_W     = 8;
  localparam int BIT_IDX_W  = $clog2(BYTE_W);

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP_S  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_SN = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_U  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP_UN = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BADCNT = 2'd1;
  localparam logic [ST_W-1:0] ST_SHORT  = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  // control from the sequencer to the field accumulator
  typedef struct packed {
    logic clear;   // start a new field
    logic shift;   // take one bit in at the bottom
    logic bit_in;  // the bit taken in
    logic ok;      // the field is a valid pop result
  } acc_ctl_t;

endpackage

/* rtl/bff_ram.sv */
// ----------------------------------------------------------------------------
// bff_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bff_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bff_acc.sv */
// ----------------------------------------------------------------------------
// bff_acc
// field accumulator: collects popped bits one per cycle while shift is set,
// first bit most significant, and forms the signed, unsigned or negated result
// ----------------------------------------------------------------------------
module bff_acc (
  input  logic                         clk,
  input  bff_pkg::acc_ctl_t            ctl,
  input  logic [bff_pkg::CMD_W-1:0]    cmd,
  input  logic [bff_pkg::CNT_W-1:0]    cnt,
  output logic [bff_pkg::VAL_W-1:0]    value
);

  logic [bff_pkg::VAL_W-1:0]     acc_r;
  logic [bff_pkg::VAL_W-1:0]     acc_nxt;
  logic [bff_pkg::VAL_IDX_W-1:0] top_idx;
  logic                          sign;
  logic [bff_pkg::VAL_W-1:0]     ext_mask;
  logic [bff_pkg::VAL_W-1:0]     top;
  logic [bff_pkg::VAL_W-1:0]     sval;
  logic [bff_pkg::VAL_W-1:0]     neg_in;
  logic [bff_pkg::VAL_W-1:0]     neg;
  logic [bff_pkg::VAL_W-1:0]     res;

  // shift register, one bit per cycle while shift is set
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.shift) begin
      acc_nxt = {acc_r[bff_pkg::VAL_W-2:0], ctl.bit_in};
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // sign extension from the first bit taken
  assign top_idx  = bff_pkg::VAL_IDX_W'(cnt - bff_pkg::CNT_W'(1));
  assign sign     = acc_r[top_idx];
  assign ext_mask = {bff_pkg::VAL_W{1'b1}} << cnt;
  assign top      = bff_pkg::VAL_W'(1) << top_idx;
  assign sval     = sign ? (acc_r | ext_mask) : acc_r;

  // one shared negation
  assign neg_in = ((cmd == bff_pkg::CMD_POP_S) || (cmd == bff_pkg::CMD_POP_SN)) ? sval : acc_r;
  assign neg    = '0 - neg_in;

  // result select per command
  always_comb begin
    case (cmd)
      bff_pkg::CMD_POP_S:  res = sval;
      // minimum value stays as it is
      bff_pkg::CMD_POP_SN: res = (sval == (ext_mask | top)) ? sval : neg;
      bff_pkg::CMD_POP_U:  res = acc_r;
      // 2^count minus the field, zero stays zero
      bff_pkg::CMD_POP_UN: res = neg & ~ext_mask;
      default:             res = '0;
    endcase
  end

  assign value = ctl.ok ? res : '0;

endmodule

/* rtl/bit_fifo_field_extractor.sv */
// ----------------------------------------------------------------------------
// bit_fifo_field_extractor
// bit fifo with byte pushes and variable-width field pops, bit-serial datapath
// ----------------------------------------------------------------------------
// Usage: one beat on the in_ channel is one command; each command returns
// exactly one beat on the out_ channel carrying value, status and bits_left.
// A push writes its eight bits into the bit store one per cycle (bit 7 or
// bit 0 first); a pop reads one bit per cycle from the store's registered
// read port and shifts it into the field accumulator.
// A push runs through S_PUSH and then S_DONE, a pop through S_POP and then
// S_DONE, and an error or unknown command goes straight to S_DONE.
// The single-bit store port and the accumulator shift set the pace.
// in_tready is high only while the sequencer is idle; the finished result
// sits in an output register, so the next command is taken while it waits.
// If the receiver stalls with a result still held, the sequencer finishes
// the next command and then holds until the output register frees up.
// Reset empties the fifo (pointers and fill count to zero) and drops any
// pending result; the bit store itself is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module bit_fifo_field_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // byte_in[7:0], msb_first[8], bit_count[14:9], zero
  input  logic [2:0]  in_tuser,   // cmd[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // value[31:0], bits_left[40:32], zero
  output logic [1:0]  out_tuser   // status[1:0]
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PUSH = 4'b0010,
    S_POP  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [bff_pkg::CMD_W-1:0]        cmd_r, cmd_nxt;
  logic [bff_pkg::BYTE_W-1:0]       byte_r, byte_nxt;
  logic                             msb_r, msb_nxt;
  logic [bff_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [bff_pkg::ST_W-1:0]         status_r, status_nxt;
  logic [bff_pkg::PTR_W-1:0]        rptr_r, rptr_nxt;
  logic [bff_pkg::PTR_W-1:0]        wptr_r, wptr_nxt;
  logic [bff_pkg::FILL_W-1:0]       fill_r, fill_nxt;
  logic [bff_pkg::BIT_IDX_W-1:0]    bitn_r, bitn_nxt;
  logic [bff_pkg::CNT_W-1:0]        rem_r, rem_nxt;
  logic                             pend_r, pend_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [bff_pkg::VAL_W-1:0]        out_value_r, out_value_nxt;
  logic [bff_pkg::FILL_W-1:0]       out_left_r, out_left_nxt;
  logic [bff_pkg::ST_W-1:0]         out_status_r, out_status_nxt;

  logic                             accept;
  logic [bff_pkg::CMD_W-1:0]        in_cmd;
  logic [bff_pkg::BYTE_W-1:0]       in_byte;
  logic                             in_msb;
  logic [bff_pkg::CNT_W-1:0]        in_cnt;
  logic                             push_bit;
  logic                             ram_we;
  logic                             ram_rdata;
  logic                             out_free;
  logic                             is_pop;
  bff_pkg::acc_ctl_t                acc_ctl;
  logic [bff_pkg::VAL_W-1:0]        acc_value;

  // input beat fields
  assign in_byte = in_tdata[7:0];
  assign in_msb  = in_tdata[8];
  assign in_cnt  = in_tdata[14:9];
  assign in_cmd  = in_tuser;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign push_bit  = msb_r ? byte_r[bff_pkg::BYTE_W-1] : byte_r[0];
  assign ram_we    = (state_r == S_PUSH);
  assign is_pop    = (cmd_r == bff_pkg::CMD_POP_S) || (cmd_r == bff_pkg::CMD_POP_SN) ||
                     (cmd_r == bff_pkg::CMD_POP_U) || (cmd_r == bff_pkg::CMD_POP_UN);

  // bit store
  bff_ram #(
    .WIDTH (1),
    .DEPTH (bff_pkg::DEPTH_BITS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr_r),
    .wdata (push_bit),
    .raddr (rptr_r),
    .rdata (ram_rdata)
  );

  // field accumulator
  always_comb begin
    acc_ctl.clear  = accept;
    acc_ctl.shift  = (state_r == S_POP) && pend_r;
    acc_ctl.bit_in = ram_rdata;
    acc_ctl.ok     = is_pop && (status_r == bff_pkg::ST_OK);
  end

  bff_acc u_acc (
    .clk   (clk),
    .ctl   (acc_ctl),
    .cmd   (cmd_r),
    .cnt   (cnt_r),
    .value (acc_value)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    byte_nxt       = byte_r;
    msb_nxt        = msb_r;
    cnt_nxt        = cnt_r;
    status_nxt     = status_r;
    rptr_nxt       = rptr_r;
    wptr_nxt       = wptr_r;
    fill_nxt       = fill_r;
    bitn_nxt       = bitn_r;
    rem_nxt        = rem_r;
    pend_nxt       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_left_nxt   = out_left_r;
    out_status_nxt = out_status_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_cmd;
          byte_nxt   = in_byte;
          msb_nxt    = in_msb;
          cnt_nxt    = in_cnt;
          bitn_nxt   = '0;
          rem_nxt    = in_cnt;
          status_nxt = bff_pkg::ST_OK;
          state_nxt  = S_DONE;
          if (in_cmd == bff_pkg::CMD_PUSH) begin
            if (({1'b0, fill_r} + (bff_pkg::FILL_W + 1)'(bff_pkg::BYTE_W)) >
                (bff_pkg::FILL_W + 1)'(bff_pkg::DEPTH_BITS)) begin
              status_nxt = bff_pkg::ST_FULL;
            end else begin
              state_nxt = S_PUSH;
            end
          end else if ((in_cmd == bff_pkg::CMD_POP_S) || (in_cmd == bff_pkg::CMD_POP_SN) ||
                       (in_cmd == bff_pkg::CMD_POP_U) || (in_cmd == bff_pkg::CMD_POP_UN)) begin
            if ((in_cnt == '0) || (in_cnt > bff_pkg::CNT_W'(bff_pkg::MAX_POP))) begin
              status_nxt = bff_pkg::ST_BADCNT;
            end else if (bff_pkg::FILL_W'(in_cnt) > fill_r) begin
              status_nxt = bff_pkg::ST_SHORT;
            end else begin
              state_nxt = S_POP;
            end
          end
        end
      end
      S_PUSH: begin
        // one bit written per cycle
        wptr_nxt = wptr_r + bff_pkg::PTR_W'(1);
        fill_nxt = fill_r + bff_pkg::FILL_W'(1);
        bitn_nxt = bitn_r + bff_pkg::BIT_IDX_W'(1);
        byte_nxt = msb_r ? {byte_r[bff_pkg::BYTE_W-2:0], 1'b0} : {1'b0, byte_r[bff_pkg::BYTE_W-1:1]};
        if (bitn_r == bff_pkg::BIT_IDX_W'(bff_pkg::BYTE_W - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_POP: begin
        // issue one read per cycle, data shifts into the accumulator in the following cycle
        if (rem_r != '0) begin
          rptr_nxt = rptr_r + bff_pkg::PTR_W'(1);
          fill_nxt = fill_r - bff_pkg::FILL_W'(1);
          rem_nxt  = rem_r - bff_pkg::CNT_W'(1);
          pend_nxt = 1'b1;
        end else if (!pend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hand the result to the output register when it is free
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = acc_value;
          out_left_nxt   = fill_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rptr_r      <= '0;
      wptr_r      <= '0;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rptr_r      <= rptr_nxt;
      wptr_r      <= wptr_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    byte_r       <= byte_nxt;
    msb_r        <= msb_nxt;
    cnt_r        <= cnt_nxt;
    status_r     <= status_nxt;
    bitn_r       <= bitn_nxt;
    rem_r        <= rem_nxt;
    out_value_r  <= out_value_nxt;
    out_left_r   <= out_left_nxt;
    out_status_r <= out_status_nxt;
  end

  // output beat
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_left_r, out_value_r};
  assign out_tuser  = out_status_r;

endmodule
